@@ hdl/rgb_histogram_engine_assert.svh @@
// Assertion macros for the RGB histogram engine.
// No dependencies; included by the top level.
`ifndef RGB_HISTOGRAM_ENGINE_ASSERT_SVH
`define RGB_HISTOGRAM_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define RGBH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RGBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RGBH_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RGBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/rgbh_pkg.sv @@
// Shared constants, types and helpers of the RGB histogram engine.
// No dependencies.
package rgbh_pkg;

    localparam int BIN_COUNT      = 256;
    localparam int COUNT_BITS     = 24;
    localparam int BIN_BITS       = $clog2(BIN_COUNT);
    localparam int OUT_COUNT_BITS = 24;
    localparam int SCALE_BITS     = 8;
    localparam int PROD_BITS      = COUNT_BITS + SCALE_BITS;
    localparam int CHANNELS       = 4;
    localparam int CH_BITS        = 2;
    localparam int QUOT_BITS      = 8;
    localparam int STEP_BITS      = $clog2(QUOT_BITS);

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 8'd100;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    // floor(x/3) for x < 768 as (x*683) >> 11
    localparam logic [9:0] THIRD_MUL   = 10'd683;
    localparam int         THIRD_SHIFT = 11;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CLEAR  = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_DIVIDE = 4'b1000
    } t_state;

    function automatic logic [BIN_BITS-1:0] bin_clamp(input logic [7:0] v);
        if ({1'b0, v} >= 9'(BIN_COUNT)) begin
            return BIN_BITS'(BIN_COUNT - 1);
        end
        return v[BIN_BITS-1:0];
    endfunction

    function automatic logic [OUT_COUNT_BITS-1:0] out_count(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

@@ hdl/rgbh_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rgbh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rgb_histogram_engine.sv @@
// RGB histogram engine top level: four bin RAMs (rgbh_ram), rgbh_pkg, assertion header.
// Pixel beats: one per cycle while not busy, read-modify-write in the cycle after the beat,
// with forwarding. Read beat: lookup, then 8-step restoring divider, then the result strobe;
// busy drops with the strobe, so the next beat can be taken at the edge that ends it.
// Clear beat: busy while clearing, one RAM row a cycle. Reset (synchronous, active low)
// starts the same clearing pass; results are strobes, no receiver stall.
`include "rgb_histogram_engine_assert.svh"

module rgb_histogram_engine
    import rgbh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [SCALE_BITS-1:0]     i_cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  logic [1:0]                i_channel,
    input  logic [7:0]                i_bin,
    output logic                      o_strobe,
    output logic [OUT_COUNT_BITS-1:0] o_count,
    output logic [7:0]                o_height,
    output logic                      o_empty_res
);

    t_state                  r_state, n_state;
    logic [SCALE_BITS-1:0]   r_scale;
    logic [BIN_BITS-1:0]     r_clr_addr;
    logic                    r_s2_pix;
    logic [BIN_BITS-1:0]     r_s2_addr [CHANNELS];
    logic [COUNT_BITS-1:0]   r_max [CHANNELS];
    logic                    r_fwd_vld [CHANNELS];
    logic [BIN_BITS-1:0]     r_fwd_addr [CHANNELS];
    logic [COUNT_BITS-1:0]   r_fwd_data [CHANNELS];
    logic [CH_BITS-1:0]      r_rd_ch;
    logic                    r_rd_oob;
    logic                    r_empty;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic [PROD_BITS-1:0]    r_rem;
    logic [PROD_BITS-1:0]    r_dsh;
    logic [QUOT_BITS-1:0]    r_quot;
    logic [STEP_BITS-1:0]    r_step;
    logic                    r_strobe;
    logic [OUT_COUNT_BITS-1:0] r_count;
    logic [7:0]              r_height;
    logic                    r_empty_res;

    logic                    accept;
    logic                    take_pix;
    logic                    take_read;
    logic                    take_clear;
    logic [9:0]              rgb_sum;
    logic [19:0]             mean_prod;
    logic [BIN_BITS-1:0]     pix_idx [CHANNELS];
    logic [BIN_BITS-1:0]     raddr [CHANNELS];
    logic [COUNT_BITS-1:0]   ram_q [CHANNELS];
    logic [COUNT_BITS-1:0]   cur [CHANNELS];
    logic [COUNT_BITS-1:0]   inc [CHANNELS];
    logic                    we [CHANNELS];
    logic [BIN_BITS-1:0]     waddr [CHANNELS];
    logic [COUNT_BITS-1:0]   wdata [CHANNELS];
    logic [COUNT_BITS-1:0]   sel_cnt;
    logic                    div_ge;
    logic                    clear_done;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign take_pix   = accept && (i_operation == OP_PIXEL);
    assign take_read  = accept && (i_operation == OP_READ);
    assign take_clear = accept && (i_operation == OP_CLEAR);
    assign clear_done = (r_clr_addr == BIN_BITS'(BIN_COUNT - 1));

    assign rgb_sum   = 10'(i_red) + 10'(i_green) + 10'(i_blue);
    assign mean_prod = 20'(rgb_sum) * 20'(THIRD_MUL);

    always_comb begin
        pix_idx[0] = bin_clamp(i_red);
        pix_idx[1] = bin_clamp(i_green);
        pix_idx[2] = bin_clamp(i_blue);
        pix_idx[3] = bin_clamp(mean_prod[THIRD_SHIFT +: 8]);
    end

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_ch
            assign raddr[c] = (i_operation == OP_READ) ? i_bin[BIN_BITS-1:0] : pix_idx[c];
            assign cur[c]   = (r_fwd_vld[c] && (r_fwd_addr[c] == r_s2_addr[c])) ?
                              r_fwd_data[c] : ram_q[c];
            assign inc[c]   = (cur[c] != COUNT_LIMIT) ? cur[c] + COUNT_BITS'(1) : cur[c];
            assign we[c]    = (r_state == ST_CLEAR) || r_s2_pix;
            assign waddr[c] = (r_state == ST_CLEAR) ? r_clr_addr : r_s2_addr[c];
            assign wdata[c] = (r_state == ST_CLEAR) ? '0 : inc[c];

            rgbh_ram #(
                .WIDTH (COUNT_BITS),
                .DEPTH (BIN_COUNT)
            ) u_bins (
                .i_clk   (i_clk),
                .i_we    (we[c]),
                .i_waddr (waddr[c]),
                .i_wdata (wdata[c]),
                .i_raddr (raddr[c]),
                .o_rdata (ram_q[c])
            );

            always_ff @(posedge i_clk) begin
                r_fwd_addr[c] <= waddr[c];
                r_fwd_data[c] <= wdata[c];
                if (accept) begin
                    r_s2_addr[c] <= raddr[c];
                end
                if (!i_rst_n) begin
                    r_fwd_vld[c] <= 1'b0;
                    r_max[c]     <= '0;
                end else begin
                    r_fwd_vld[c] <= we[c];
                    if (take_clear) begin
                        r_max[c] <= '0;
                    end else if (r_s2_pix && (inc[c] > r_max[c])) begin
                        r_max[c] <= inc[c];
                    end
                end
            end
        end
    endgenerate

    assign sel_cnt = r_rd_oob ? '0 : cur[r_rd_ch];
    assign div_ge  = (r_rem >= r_dsh);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take_clear) begin
                    n_state = ST_CLEAR;
                end else if (take_read) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_CLEAR: begin
                if (clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOKUP: n_state = ST_DIVIDE;
            ST_DIVIDE: begin
                if (r_step == STEP_BITS'(QUOT_BITS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_scale    <= SCALE_RESET;
            r_s2_pix   <= 1'b0;
            r_step     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s2_pix <= take_pix;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_scale <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clear_done ? '0 : r_clr_addr + BIN_BITS'(1);
            end
            if (r_state == ST_LOOKUP) begin
                r_step <= '0;
            end else if (r_state == ST_DIVIDE) begin
                r_step <= r_step + STEP_BITS'(1);
                if (r_step == STEP_BITS'(QUOT_BITS - 1)) begin
                    r_strobe <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_read) begin
            r_rd_ch  <= i_channel;
            r_rd_oob <= ({1'b0, i_bin} >= 9'(BIN_COUNT));
        end
        if (r_state == ST_LOOKUP) begin
            r_cnt   <= sel_cnt;
            r_empty <= (r_max[r_rd_ch] == '0);
            r_rem   <= PROD_BITS'(sel_cnt) * PROD_BITS'(r_scale);
            r_dsh   <= PROD_BITS'(r_max[r_rd_ch]) << (QUOT_BITS - 1);
            r_quot  <= '0;
        end else if (r_state == ST_DIVIDE) begin
            r_rem  <= div_ge ? r_rem - r_dsh : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[QUOT_BITS-2:0], div_ge};
            if (r_step == STEP_BITS'(QUOT_BITS - 1)) begin
                r_count     <= out_count(r_cnt);
                r_height    <= r_empty ? '0 : {r_quot[QUOT_BITS-2:0], div_ge};
                r_empty_res <= r_empty;
            end
        end
    end

    assign o_strobe    = r_strobe;
    assign o_count     = r_count;
    assign o_height    = r_height;
    assign o_empty_res = r_empty_res;

    `RGBH_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe)
    `RGBH_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_strobe && o_empty_res, o_height == 8'd0)
    `RGBH_ASSERT_IMPLY(a_clear_no_pix, i_clk, i_rst_n, r_state == ST_CLEAR, !r_s2_pix)
    `RGBH_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, take_read, busy && !o_strobe)

endmodule
